// ===== hdl/pstu_pkg.sv =====
// types, codes and constants shared by the particle store blocks
`timescale 1ns / 1ps
package pstu_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 512;
  localparam int unsigned DIV_W             = 41;
  localparam logic [15:0] LIFE_FULL         = 16'h8000;
  localparam int          GRAVITY_DROP      = 20;
  localparam int          ONE_Q12           = 4096;
  localparam logic [31:0] BH_MIN_D2         = 32'd1678;
  localparam logic [6:0]  BH_SCALE          = 7'd100;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_STEP  = 3'd1,
    ACT_AGE   = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    MODE_STILL      = 2'd0,
    MODE_GRAVITY    = 2'd1,
    MODE_BLACK_HOLE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SIM_MODE  = 2'd0,
    CFG_TIME_STEP = 2'd1,
    CFG_WIN_W     = 2'd2,
    CFG_WIN_H     = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FETCH,
    ST_SQUARE,
    ST_SUM,
    ST_SCALE,
    ST_XGO,
    ST_XWAIT,
    ST_YGO,
    ST_YWAIT,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [8:0]  read_index;
  } req_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        life_left;
    logic               is_alive;
    logic               entry_present;
  } res_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        life;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic             rem_nz;
  } div_rsp_t;

endpackage

// ===== hdl/pstu_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pstu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pstu_pkg::div_req_t req_i,
  output pstu_pkg::div_rsp_t rsp_o
);
  import pstu_pkg::*;

  localparam int unsigned CNTW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = CNTW'(DIV_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (diff[DIV_W+1]) begin
        rem_d = shifted[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end else begin
        rem_d = diff[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quo_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// ===== hdl/pstu_mem.sv =====
// particle entry memory, one write and one registered read port
`timescale 1ns / 1ps
module pstu_mem #(
  parameter int unsigned DEPTH = pstu_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  pstu_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output pstu_pkg::entry_t rdata_o
);
  import pstu_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/particle_store_update.sv =====
// particle store: ring of entries with add, step, age, clear and read requests
//
// usage: a request is taken when start_i is high and busy_o is low; req_i
// carries the action and its operands. reads return one result on res_o,
// marked by res_valid_o for one cycle; other actions return nothing. the
// receiver cannot stall, so a result is shown once and is gone.
// configuration goes through cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; ready is always high, writes are meant for idle periods.
// work per request: clear resets the ring; a read fetches its entry; add
// runs two serial divisions in the shared divider, then a write; step and
// age loop over the stored entries through the memory read and write ports:
// a live particle is fetched and written back, a dead one only fetched, and
// in black hole mode two divisions come before the write unless it sits at
// the centre. a step in still mode leaves the entries as they are.
// reset empties the ring and loads the register defaults; entry memory is
// not cleared and needs no sweep, as only written entries are ever read.
`timescale 1ns / 1ps
module particle_store_update #(
  parameter int unsigned MAX_PARTICLES = pstu_pkg::MAX_PARTICLES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pstu_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output pstu_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);
  import pstu_pkg::*;

  localparam int unsigned SW   = $clog2(MAX_PARTICLES);
  localparam int unsigned CW   = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CMPW = (CW > 9) ? CW : 9;
  localparam logic [SW:0] MAXV = (SW + 1)'(MAX_PARTICLES);

  function automatic logic [SW-1:0] wrap(input logic [SW:0] s);
    logic [SW:0] t;
    t = (s >= MAXV) ? s - MAXV : s;
    return t[SW-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
    logic signed [15:0] r;
    if (v > 44'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -44'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SW-1:0]     oldest_q, oldest_d;
  entry_t            cur_q, cur_d;
  logic signed [15:0] nx_q, nx_d, ny_q, ny_d;
  logic [31:0]       sqx_q, sqx_d, sqy_q, sqy_d, d2_q, d2_d;
  logic [38:0]       den_q, den_d;
  logic              neg_q, neg_d;
  res_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic [1:0]        sim_mode_q;
  logic [15:0]       time_step_q;
  logic [12:0]       win_w_q, win_h_q;

  logic              mem_we, mem_re;
  logic [SW-1:0]     mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept, sel_y, is_add, full, present;
  logic [CMPW-1:0]   idx_c;
  logic [SW-1:0]     step_slot, add_slot, read_slot;
  logic [12:0]       w_eff, h_eff, d_sel;
  logic signed [14:0] n_x, n_y, n_sel;
  logic signed [29:0] big_n;
  logic [28:0]       mag_n;
  logic signed [15:0] coord;
  logic [15:0]       mag_c;
  logic signed [43:0] q_e, q_add, q_res;
  logic [15:0]       life_new;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sim_mode_q  <= MODE_STILL;
      time_step_q <= 16'd164;
      win_w_q     <= 13'd500;
      win_h_q     <= 13'd500;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SIM_MODE:  sim_mode_q  <= cfg_data_i[1:0];
        CFG_TIME_STEP: time_step_q <= cfg_data_i;
        CFG_WIN_W:     win_w_q     <= cfg_data_i[12:0];
        CFG_WIN_H:     win_h_q     <= cfg_data_i[12:0];
      endcase
    end
  end

  // slot arithmetic
  always_comb begin
    full      = (count_q == CW'(MAX_PARTICLES));
    idx_c     = CMPW'(req_i.read_index);
    present   = idx_c < CMPW'(count_q);
    step_slot = wrap({1'b0, oldest_q} + {1'b0, i_q[SW-1:0]});
    add_slot  = full ? oldest_q : wrap({1'b0, oldest_q} + {1'b0, count_q[SW-1:0]});
    read_slot = wrap({1'b0, oldest_q} + (SW + 1)'(req_q.read_index));
  end

  // divider operands
  always_comb begin
    sel_y  = (state_q == ST_YGO) || (state_q == ST_YWAIT);
    is_add = (req_q.action == ACT_ADD);
    w_eff  = (win_w_q == 13'd0) ? 13'd1 : win_w_q;
    h_eff  = (win_h_q == 13'd0) ? 13'd1 : win_h_q;
    n_x    = $signed({3'b000, req_q.pixel_x});
    n_y    = $signed({2'b00, h_eff}) - $signed({3'b000, req_q.pixel_y});
    n_sel  = sel_y ? n_y : n_x;
    d_sel  = sel_y ? h_eff : w_eff;
    big_n  = $signed({n_sel[14], n_sel, 14'd0}) + $signed({17'd0, d_sel});
    mag_n  = big_n[29] ? 29'(-big_n) : big_n[28:0];
    coord  = sel_y ? cur_q.y : cur_q.x;
    mag_c  = coord[15] ? 16'(-coord) : coord;
    div_req.start = (state_q == ST_XGO) || (state_q == ST_YGO);
    if (is_add) begin
      div_req.num = DIV_W'(mag_n);
      div_req.den = DIV_W'({d_sel, 1'b0});
    end else begin
      div_req.num = (DIV_W'(mag_c) << 25) + DIV_W'(den_q);
      div_req.den = DIV_W'({den_q, 1'b0});
    end
  end

  // quotient to coordinate
  always_comb begin
    q_e   = $signed({3'b000, div_rsp.quot});
    q_add = q_e + 44'(div_rsp.rem_nz);
    if (is_add) begin
      if (!neg_q) begin
        q_res = q_e - 44'(ONE_Q12);
      end else begin
        q_res = -q_add - 44'(ONE_Q12);
      end
    end else if (coord > 16'sd0) begin
      q_res = 44'(coord) - q_e;
    end else begin
      q_res = 44'(coord) + q_e;
    end
    life_new = (cur_q.life > time_step_q) ? cur_q.life - time_step_q : 16'd0;
  end

  pstu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pstu_mem #(
    .DEPTH (MAX_PARTICLES),
    .AW    (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (req_i.action == ACT_ADD) begin
            state_d = ST_XGO;
          end else if (req_i.action == ACT_AGE) begin
            state_d = ST_ISSUE;
          end else if (req_i.action == ACT_STEP &&
                       (sim_mode_q == MODE_GRAVITY || sim_mode_q == MODE_BLACK_HOLE)) begin
            state_d = ST_ISSUE;
          end else if (req_i.action == ACT_READ && present) begin
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ISSUE: begin
        if (req_q.action != ACT_READ && i_q == count_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        priority if (req_q.action == ACT_READ) begin
          state_d = ST_IDLE;
        end else if (mem_rdata.life == 16'd0) begin
          state_d = ST_ISSUE;
        end else if (req_q.action == ACT_STEP && sim_mode_q == MODE_BLACK_HOLE) begin
          state_d = ST_SQUARE;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_SCALE;
      ST_SCALE:  state_d = (d2_q >= BH_MIN_D2) ? ST_XGO : ST_WRITE;
      ST_XGO:    state_d = ST_XWAIT;
      ST_XWAIT:  state_d = div_rsp.done ? ST_YGO : ST_XWAIT;
      ST_YGO:    state_d = ST_YWAIT;
      ST_YWAIT:  state_d = div_rsp.done ? ST_WRITE : ST_YWAIT;
      ST_WRITE:  state_d = is_add ? ST_IDLE : ST_ISSUE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d       = req_q;
    i_d         = i_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    cur_d       = cur_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    d2_d        = d2_q;
    den_d       = den_q;
    neg_d       = neg_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = step_slot;
    mem_we      = 1'b0;
    mem_waddr   = is_add ? add_slot : step_slot;
    mem_wdata   = '{x: nx_q, y: ny_q, life: is_add ? LIFE_FULL : life_new};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          i_d   = '0;
          if (req_i.action == ACT_CLEAR) begin
            count_d  = '0;
            oldest_d = '0;
          end
          if (req_i.action == ACT_READ && !present) begin
            res_d       = '0;
            res_valid_d = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = (req_q.action == ACT_READ) ? read_slot : step_slot;
      end
      ST_FETCH: begin
        cur_d = mem_rdata;
        nx_d  = mem_rdata.x;
        ny_d  = mem_rdata.y;
        if (req_q.action == ACT_STEP && sim_mode_q == MODE_GRAVITY) begin
          ny_d = sat16(44'(mem_rdata.y) - 44'(GRAVITY_DROP));
        end
        if (req_q.action == ACT_READ) begin
          res_d.pos_x         = mem_rdata.x;
          res_d.pos_y         = mem_rdata.y;
          res_d.life_left     = mem_rdata.life;
          res_d.is_alive      = (mem_rdata.life != 16'd0);
          res_d.entry_present = 1'b1;
          res_valid_d         = 1'b1;
        end else if (mem_rdata.life == 16'd0) begin
          i_d = i_q + CW'(1);
        end
      end
      ST_SQUARE: begin
        sqx_d = 32'(cur_q.x * cur_q.x);
        sqy_d = 32'(cur_q.y * cur_q.y);
      end
      ST_SUM: begin
        d2_d = sqx_q + sqy_q;
      end
      ST_SCALE: begin
        den_d = 39'(d2_q) * 39'(BH_SCALE);
      end
      ST_XGO, ST_YGO: begin
        neg_d = big_n[29];
      end
      ST_XWAIT: begin
        if (div_rsp.done) begin
          nx_d = sat16(q_res);
        end
      end
      ST_YWAIT: begin
        if (div_rsp.done) begin
          ny_d = sat16(q_res);
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        if (is_add) begin
          if (full) begin
            oldest_d = wrap({1'b0, oldest_q} + (SW + 1)'(1));
          end else begin
            count_d = count_q + CW'(1);
          end
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      count_q     <= '0;
      oldest_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cur_q  <= cur_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    d2_q   <= d2_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

endmodule

// ===== sim/particle_store_update_test.sv =====
// testbench for the particle store: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module particle_store_update_test;
  import pstu_pkg::*;

  localparam int unsigned DEPTH = MAX_PARTICLES_DEF;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  class store_scoreboard;
    logic signed [15:0] ent_x[DEPTH];
    logic signed [15:0] ent_y[DEPTH];
    logic [15:0]        ent_life[DEPTH];
    int unsigned        oldest, count;
    logic [1:0]         mode;
    logic [15:0]        tstep;
    logic [12:0]        win_w, win_h;
    res_t               pending[$];
    int unsigned        errors, reads_seen, adds, steps, ages, clears;

    function void reset_state();
      oldest = 0; count = 0; mode = MODE_STILL; tstep = 16'd164;
      win_w = 13'd500; win_h = 13'd500;
    endfunction

    function void write_reg(cfg_index_e idx, logic [15:0] data);
      case (idx)
        CFG_SIM_MODE:  mode = data[1:0];
        CFG_TIME_STEP: tstep = data;
        CFG_WIN_W:     win_w = data[12:0];
        CFG_WIN_H:     win_h = data[12:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
    endfunction

    function logic signed [15:0] to_unit(longint n, longint d);
      longint num, den, q;
      num = 2 * n * 8192 + d;
      den = 2 * d;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return sat16(q - ONE_Q12);
    endfunction

    function longint attract(longint d, longint d2);
      longint mag, q;
      mag = d < 0 ? -d : d;
      q = (mag * 2 * 16777216 + 100 * d2) / (200 * d2);
      return d < 0 ? -q : q;
    endfunction

    function void accept(req_t r);
      longint w, h, dx, dy, d2;
      int unsigned s;
      res_t e;
      case (r.action)
        ACT_ADD: begin
          adds++;
          w = win_w == 0 ? 1 : win_w;
          h = win_h == 0 ? 1 : win_h;
          if (count < DEPTH) begin
            s = (oldest + count) % DEPTH;
            count++;
          end else begin
            s = oldest;
            oldest = (oldest + 1) % DEPTH;
          end
          ent_x[s] = to_unit(r.pixel_x, w);
          ent_y[s] = to_unit(h - r.pixel_y, h);
          ent_life[s] = LIFE_FULL;
        end
        ACT_STEP, ACT_AGE: begin
          if (r.action == ACT_AGE) ages++; else steps++;
          if (!(r.action == ACT_STEP && (mode == MODE_STILL || mode == MODE_SPARE)))
            for (int i = 0; i < count; i++) begin
              s = (oldest + i) % DEPTH;
              if (ent_life[s] == 0) continue;
              if (r.action == ACT_STEP && mode == MODE_GRAVITY)
                ent_y[s] = sat16(longint'(ent_y[s]) - GRAVITY_DROP);
              else if (r.action == ACT_STEP && mode == MODE_BLACK_HOLE) begin
                dx = -longint'(ent_x[s]);
                dy = -longint'(ent_y[s]);
                d2 = dx * dx + dy * dy;
                if (d2 * 10000 > 16777216) begin
                  ent_x[s] = sat16(longint'(ent_x[s]) + attract(dx, d2));
                  ent_y[s] = sat16(longint'(ent_y[s]) + attract(dy, d2));
                end
              end
              ent_life[s] = ent_life[s] > tstep ? ent_life[s] - tstep : 16'd0;
            end
        end
        ACT_CLEAR: begin
          clears++;
          count = 0; oldest = 0;
        end
        ACT_READ: begin
          e = '0;
          if (r.read_index < count) begin
            s = (oldest + r.read_index) % DEPTH;
            e.pos_x = ent_x[s];
            e.pos_y = ent_y[s];
            e.life_left = ent_life[s];
            e.is_alive = ent_life[s] != 0;
            e.entry_present = 1'b1;
          end
          pending = {pending, e};
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("%0t ns: %s", $time, what);
    endtask

    task check(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report("result with no read request outstanding");
        return;
      end
      e = pending.pop_front();
      reads_seen++;
      if (got.pos_x !== e.pos_x)
        report($sformatf("pos_x %0d, predicted %0d", got.pos_x, e.pos_x));
      if (got.pos_y !== e.pos_y)
        report($sformatf("pos_y %0d, predicted %0d", got.pos_y, e.pos_y));
      if (got.life_left !== e.life_left)
        report($sformatf("life_left %0d, predicted %0d", got.life_left, e.life_left));
      if (got.is_alive !== e.is_alive)
        report($sformatf("is_alive %b, predicted %b", got.is_alive, e.is_alive));
      if (got.entry_present !== e.entry_present)
        report($sformatf("entry_present %b, predicted %b",
                         got.entry_present, e.entry_present));
    endtask
  endclass

  logic        clk_i, rst_ni, start_i, busy_o, res_valid_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  req_t        req_i;
  res_t        res_o;
  int unsigned idle_pct;
  store_scoreboard sb;

  particle_store_update dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i)
    if (rst_ni && res_valid_o) sb.check(res_o);

  task send(logic [2:0] act, logic [11:0] x, logic [11:0] y, logic [8:0] idx);
    req_t r;
    r.action = act; r.pixel_x = x; r.pixel_y = y; r.read_index = idx;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    sb.accept(r);
  endtask

  task settle();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task write_reg(cfg_index_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task setup(logic [1:0] m, logic [15:0] ts, logic [15:0] w, logic [15:0] h);
    settle();
    write_reg(CFG_SIM_MODE, {14'd0, m});
    write_reg(CFG_TIME_STEP, ts);
    write_reg(CFG_WIN_W, w);
    write_reg(CFG_WIN_H, h);
  endtask

  task random_request();
    int unsigned pick;
    logic [8:0] idx;
    pick = $urandom_range(99);
    if (sb.count > 40 && pick < 10) begin
      send(ACT_CLEAR, 12'($urandom), 12'($urandom), 9'($urandom));
      return;
    end
    idx = $urandom_range(99) < 75 ? 9'($urandom_range(sb.count + 1 < 511 ? sb.count + 1 : 511))
                                  : 9'($urandom);
    if (pick < 32) send(ACT_ADD, 12'($urandom), 12'($urandom), 9'($urandom));
    else if (pick < 68) send(ACT_READ, 12'($urandom), 12'($urandom), idx);
    else if (pick < 82) send(ACT_STEP, 12'($urandom), 12'($urandom), 9'($urandom));
    else if (pick < 92) send(ACT_AGE, 12'($urandom), 12'($urandom), 9'($urandom));
    else if (pick < 96) send(ACT_CLEAR, 12'($urandom), 12'($urandom), 9'($urandom));
    else send(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), 12'($urandom),
              12'($urandom), idx);
  endtask

  initial begin
    #500ms;
    $display("particle_store_update: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    idle_pct = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_SIM_MODE;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, corners, each action and mode
    send(ACT_READ, 0, 0, 0);
    send(ACT_READ, 0, 0, 9'd511);
    send(ACT_ADD, 0, 0, 0);
    send(ACT_ADD, 12'hfff, 12'hfff, 0);
    send(ACT_ADD, 250, 250, 0);
    send(ACT_STEP, 0, 0, 0);
    setup(MODE_GRAVITY, 16'd164, 16'd500, 16'd500);
    send(ACT_ADD, 251, 249, 0);
    send(ACT_STEP, 0, 0, 0);
    send(ACT_AGE, 0, 0, 0);
    for (int i = 0; i < 5; i++) send(ACT_READ, 0, 0, 9'(i));
    send(ACT_UNUSED_LO, 0, 0, 0);
    send(ACT_UNUSED_HI, 0, 0, 0);
    setup(MODE_BLACK_HOLE, 16'd32768, 16'd1, 16'd1);
    send(ACT_ADD, 12'hfff, 12'hfff, 0);
    send(ACT_STEP, 0, 0, 0);
    send(ACT_READ, 0, 0, 0);
    send(ACT_READ, 0, 0, 9'd4);
    send(ACT_STEP, 0, 0, 0);
    send(ACT_READ, 0, 0, 9'd4);
    send(ACT_CLEAR, 0, 0, 0);
    send(ACT_READ, 0, 0, 0);
    setup(MODE_SPARE, 16'd0, 16'h1fff, 16'd0);
    send(ACT_ADD, 12'hfff, 0, 0);
    send(ACT_STEP, 0, 0, 0);
    send(ACT_AGE, 0, 0, 0);
    send(ACT_READ, 0, 0, 0);

    // fill past capacity so the ring overwrites its oldest entries
    setup(MODE_STILL, 16'hffff, 16'd4096, 16'd4096);
    for (int i = 0; i < DEPTH + 9; i++) send(ACT_ADD, 12'($urandom), 12'($urandom), 0);
    send(ACT_READ, 0, 0, 0);
    send(ACT_READ, 0, 0, 9'd511);
    send(ACT_AGE, 0, 0, 0);
    send(ACT_READ, 0, 0, 9'd100);
    send(ACT_CLEAR, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setup(MODE_BLACK_HOLE, 16'd164, 16'd500, 16'd500);
        1: setup(MODE_GRAVITY, 16'd2000, 16'd640, 16'd480);
        2: setup(MODE_BLACK_HOLE, 16'($urandom_range(0, 32768)),
                 16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
        3: setup(MODE_STILL, 16'd700, 16'd1, 16'd4096);
        4: setup(MODE_GRAVITY, 16'd0, 16'd4096, 16'd1);
        default: setup(MODE_BLACK_HOLE, 16'd32768, 16'd4096, 16'd4096);
      endcase
      for (int i = 0; i < 75; i++) begin
        idle_pct = ph < 2 ? 7 : (ph < 4 ? 67 : 0);
        random_request();
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d adds, %0d steps, %0d ages, %0d clears; %0d reads checked",
             sb.adds, sb.steps, sb.ages, sb.clears, sb.reads_seen);
    $display("ring wrap, all modes including the spare one, window and life extremes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("particle_store_update: match");
    end else begin
      $display("particle_store_update: mismatch");
    end
    $finish;
  end
endmodule
